/* src/stacc_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse term accumulator package
// Shared constants, result status codes and the command kind type.
// ----------------------------------------------------------------------------
package stacc_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_EXP_BITS    = 8;
   localparam int MAX_RESULTS     = 64;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_DUMP  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [2:0] ST_MERGED    = 3'd0;
   localparam logic [2:0] ST_APPENDED  = 3'd1;
   localparam logic [2:0] ST_CANCELLED = 3'd2;
   localparam logic [2:0] ST_ZERO      = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_DUMP      = 3'd5;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_SKIP  = 2'd1,
      KIND_DUMP  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

endpackage

/* src/stacc_front.sv */
// ----------------------------------------------------------------------------
// Sparse term accumulator front end
// Accepts command words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module stacc_front #(
   parameter int EXP_BITS = stacc_pkg::DEF_EXP_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_func,
   input  logic signed [31:0]      req_coeff,
   input  logic [7:0]              req_x_exp,
   input  logic [7:0]              req_y_exp,
   input  logic [7:0]              req_z_exp,
   output logic                    q_valid,
   input  logic                    q_pop,
   output stacc_pkg::kind_type     q_kind,
   output logic [31:0]             q_coeff,
   output logic [3*EXP_BITS-1:0]   q_key
);
   import stacc_pkg::*;

   localparam int KW = 3 * EXP_BITS;

   kind_type          kind_ff  [2];
   logic [31:0]       coeff_ff [2];
   logic [KW-1:0]     key_ff   [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   kind_type          kind_c;
   logic              keep_c;
   logic              push_c;
   logic [15:0]       x_w, y_w, z_w;

   assign busy = (count_ff == 2'd2);

   always_comb begin
      x_w    = 16'(req_x_exp);
      y_w    = 16'(req_y_exp);
      z_w    = 16'(req_z_exp);
      keep_c = 1'b1;
      kind_c = KIND_ADD;
      case (req_func)
         FUNC_ADD:   kind_c = (req_coeff == 32'sd0) ? KIND_SKIP : KIND_ADD;
         FUNC_DUMP:  kind_c = KIND_DUMP;
         FUNC_CLEAR: kind_c = KIND_CLEAR;
         default:    keep_c = 1'b0;   // drop the unused code
      endcase
      push_c    = start && !busy && keep_c;
      wr_ptr_in = wr_ptr_ff ^ push_c;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push_c) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_c) begin
         kind_ff[wr_ptr_ff]  <= kind_c;
         coeff_ff[wr_ptr_ff] <= req_coeff;
         key_ff[wr_ptr_ff]   <= {x_w[EXP_BITS-1:0], y_w[EXP_BITS-1:0], z_w[EXP_BITS-1:0]};
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_kind  = kind_ff[rd_ptr_ff];
   assign q_coeff = coeff_ff[rd_ptr_ff];
   assign q_key   = key_ff[rd_ptr_ff];

endmodule

/* src/stacc_back.sv */
// ----------------------------------------------------------------------------
// Sparse term accumulator back end
// Term table in a row of cells with parallel match, merge, removal and dump.
// ----------------------------------------------------------------------------
module stacc_back #(
   parameter int TABLE_DEPTH = stacc_pkg::DEF_TABLE_DEPTH,
   parameter int EXP_BITS    = stacc_pkg::DEF_EXP_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  stacc_pkg::kind_type     q_kind,
   input  logic [31:0]             q_coeff,
   input  logic [3*EXP_BITS-1:0]   q_key,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic                    rsp_term_valid,
   output logic signed [31:0]      rsp_out_coeff,
   output logic [7:0]              rsp_out_x,
   output logic [7:0]              rsp_out_y,
   output logic [7:0]              rsp_out_z,
   output logic                    rsp_last
);
   import stacc_pkg::*;

   localparam int KW = 3 * EXP_BITS;
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_MATCH  = 4'b0010,
      S_UPDATE = 4'b0100,
      S_DUMP   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       cell_coeff_ff [TABLE_DEPTH];
   logic [KW-1:0]     cell_key_ff   [TABLE_DEPTH];
   logic [LW-1:0]     live_ff, live_in;
   logic [LW-1:0]     dump_n_ff, dump_n_in;
   logic [LW-1:0]     dump_cnt_ff, dump_cnt_in;
   logic [31:0]       cmd_coeff_ff;
   logic [KW-1:0]     cmd_key_ff;
   logic              hit_ff;
   logic [IW-1:0]     idx_ff;

   logic [TABLE_DEPTH-1:0] match_c;
   logic [IW-1:0]     idx_c;
   logic [31:0]       sum_c;
   logic [LW-1:0]     n_c;

   logic              rsp_valid_in;
   logic [2:0]        rsp_status_in;
   logic              rsp_term_in;
   logic              rsp_last_in;

   logic              do_merge, do_remove, do_append, do_rotate;
   logic [15:0]       ox_w, oy_w, oz_w;

   // Parallel compare over live cells and one-hot to index encode.
   always_comb begin
      idx_c = '0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         match_c[j] = (LW'(j) < live_ff) && (cell_key_ff[j] == cmd_key_ff);
         if (match_c[j]) idx_c = idx_c | IW'(j);
      end
   end

   assign sum_c = cell_coeff_ff[idx_ff] + cmd_coeff_ff;
   assign n_c   = (32'(live_ff) > MAX_RESULTS) ? LW'(MAX_RESULTS) : live_ff;

   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      dump_n_in     = dump_n_ff;
      dump_cnt_in   = dump_cnt_ff;
      q_pop         = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_DUMP;
      rsp_term_in   = 1'b0;
      rsp_last_in   = 1'b1;
      do_merge      = 1'b0;
      do_remove     = 1'b0;
      do_append     = 1'b0;
      do_rotate     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_kind)
                  KIND_ADD:  state_in = S_MATCH;
                  KIND_SKIP: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_ZERO;
                  end
                  KIND_DUMP: begin
                     if (n_c == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        dump_n_in   = n_c;
                        dump_cnt_in = n_c;
                        state_in    = S_DUMP;
                     end
                  end
                  KIND_CLEAR: begin
                     live_in      = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_MATCH: state_in = S_UPDATE;
         S_UPDATE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (hit_ff) begin
               if (sum_c == 32'd0) begin
                  do_remove     = 1'b1;
                  live_in       = live_ff - LW'(1);
                  rsp_status_in = ST_CANCELLED;
               end else begin
                  do_merge      = 1'b1;
                  rsp_status_in = ST_MERGED;
               end
            end else if (live_ff < LW'(TABLE_DEPTH)) begin
               do_append     = 1'b1;
               live_in       = live_ff + LW'(1);
               rsp_status_in = ST_APPENDED;
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         S_DUMP: begin
            do_rotate    = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_term_in  = 1'b1;
            rsp_last_in  = (dump_cnt_ff == LW'(1));
            dump_cnt_in  = dump_cnt_ff - LW'(1);
            if (dump_cnt_ff == LW'(1)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         live_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         live_ff   <= live_in;
         rsp_valid <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_n_ff   <= dump_n_in;
      dump_cnt_ff <= dump_cnt_in;
      if (q_pop) begin
         cmd_coeff_ff <= q_coeff;
         cmd_key_ff   <= q_key;
      end
      if (state_ff == S_MATCH) begin
         hit_ff <= |match_c;
         idx_ff <= idx_c;
      end
   end

   // Cell updates: merge in place, close up on removal, append, rotate on dump.
   always_ff @(posedge clock) begin
      for (int j = 0; j < TABLE_DEPTH; j++) begin
         if (do_merge && (IW'(j) == idx_ff)) begin
            cell_coeff_ff[j] <= sum_c;
         end else if (do_remove && (IW'(j) >= idx_ff) && (j + 1 < TABLE_DEPTH)) begin
            cell_coeff_ff[j] <= cell_coeff_ff[(j + 1) % TABLE_DEPTH];
            cell_key_ff[j]   <= cell_key_ff[(j + 1) % TABLE_DEPTH];
         end else if (do_append && (LW'(j) == live_ff)) begin
            cell_coeff_ff[j] <= cmd_coeff_ff;
            cell_key_ff[j]   <= cmd_key_ff;
         end else if (do_rotate && (LW'(j) < dump_n_ff)) begin
            if (LW'(j + 1) == dump_n_ff) begin
               cell_coeff_ff[j] <= cell_coeff_ff[0];
               cell_key_ff[j]   <= cell_key_ff[0];
            end else begin
               cell_coeff_ff[j] <= cell_coeff_ff[(j + 1) % TABLE_DEPTH];
               cell_key_ff[j]   <= cell_key_ff[(j + 1) % TABLE_DEPTH];
            end
         end
      end
   end

   assign ox_w = 16'(cell_key_ff[0][3*EXP_BITS-1:2*EXP_BITS]);
   assign oy_w = 16'(cell_key_ff[0][2*EXP_BITS-1:EXP_BITS]);
   assign oz_w = 16'(cell_key_ff[0][EXP_BITS-1:0]);

   always_ff @(posedge clock) begin
      rsp_status     <= rsp_status_in;
      rsp_term_valid <= rsp_term_in;
      rsp_last       <= rsp_last_in;
      rsp_out_coeff  <= rsp_term_in ? cell_coeff_ff[0] : 32'sd0;
      rsp_out_x      <= rsp_term_in ? ox_w[7:0] : 8'd0;
      rsp_out_y      <= rsp_term_in ? oy_w[7:0] : 8'd0;
      rsp_out_z      <= rsp_term_in ? oz_w[7:0] : 8'd0;
   end

endmodule

/* src/sparse_term_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// Sparse term accumulator unit
// Insertion-ordered table of three-exponent polynomial terms with add,
// dump and clear commands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Word
// req_*     in         start & !busy       func, coeff, x/y/z exponents
// rsp_*     out        rsp_valid strobe    status, term, coeff, x/y/z, last
//
// An add passes through the back end in order (dequeue, parallel match over the
// cells, update); a zero add or clear is answered at dequeue; a dump streams one term per
// cycle. The match and update pass through the single row of table cells.
// Reset empties the table and the command queue; no clearing pass is needed.
// busy rises only when the two-entry command queue is full. The receiver
// cannot stall: each result stands for one cycle.
// ----------------------------------------------------------------------------
module sparse_term_accumulator_unit #(
   parameter int TABLE_DEPTH = stacc_pkg::DEF_TABLE_DEPTH,
   parameter int EXP_BITS    = stacc_pkg::DEF_EXP_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_func,
   input  logic signed [31:0]  req_coeff,
   input  logic [7:0]          req_x_exp,
   input  logic [7:0]          req_y_exp,
   input  logic [7:0]          req_z_exp,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic                rsp_term_valid,
   output logic signed [31:0]  rsp_out_coeff,
   output logic [7:0]          rsp_out_x,
   output logic [7:0]          rsp_out_y,
   output logic [7:0]          rsp_out_z,
   output logic                rsp_last
);
   import stacc_pkg::*;

   logic                  q_valid;
   logic                  q_pop;
   kind_type              q_kind;
   logic [31:0]           q_coeff;
   logic [3*EXP_BITS-1:0] q_key;

   // Classify and queue incoming words.
   stacc_front #(.EXP_BITS(EXP_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_func  (req_func),
      .req_coeff (req_coeff),
      .req_x_exp (req_x_exp),
      .req_y_exp (req_y_exp),
      .req_z_exp (req_z_exp),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_kind    (q_kind),
      .q_coeff   (q_coeff),
      .q_key     (q_key)
   );

   // Execute commands against the term table.
   stacc_back #(.TABLE_DEPTH(TABLE_DEPTH), .EXP_BITS(EXP_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_kind         (q_kind),
      .q_coeff        (q_coeff),
      .q_key          (q_key),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_term_valid (rsp_term_valid),
      .rsp_out_coeff  (rsp_out_coeff),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_last       (rsp_last)
   );

endmodule
